/* rtl/core/sdnn_pkg.sv */
`default_nettype none
package sdnn_pkg;

  localparam int INTERVAL_W   = 12;
  localparam int THRESH_W     = 12;
  localparam int DEV_W        = 15;
  localparam int USED_W       = 7;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 32;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd50;
  localparam logic [DEV_W-1:0]    DEV_MAX      = 15'd32767;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_LOAD,
    ST_ROOT,
    ST_DIV,
    ST_DONE
  } sdnn_state_t;

  typedef struct packed {
    logic acc_en;    // accumulate the interval on this transfer
    logic mul_en;    // n*sumsq, sum^2, threshold*n
    logic sub_en;    // spread and threshold square
    logic load_en;   // seed square root and divider
    logic root_en;   // one square-root step
    logic div_en;    // one quotient bit
    logic out_load;  // capture result, clear the run
  } sdnn_cmd_t;

  typedef struct packed {
    logic few;       // fewer than two intervals held
    logic out_busy;  // result register full and not taken this cycle
  } sdnn_status_t;

endpackage
`default_nettype wire

/* rtl/core/rr_interval_sdnn_irregularity_top.sv */
// Standard deviation of a run of beat-to-beat intervals. Intervals arrive one
// per transfer; while a run is open in_tready stays high and each is summed
// into count, sum and sum of squares (up to MAX_INTERVALS, later ones are
// dropped and flagged). The transfer with in_tlast set closes the run:
// in_tready then stays low while the closing arithmetic runs, which ends
// with the bit-per-cycle square root and the bit-per-cycle divide by n that
// follows it. With fewer than two intervals the square root and divide are
// skipped. The result sits in an output register until taken; a new run may
// start while it waits. If an earlier result is still waiting when the next
// run closes, in_tready stays low until that result is taken. The threshold
// is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// the block is idle, which the block itself does not enforce.
`default_nettype none
module rr_interval_sdnn_irregularity_top #(
  parameter int MAX_INTERVALS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [sdnn_pkg::IN_TDATA_W-1:0]     in_tdata,   // [11:0] interval_ms
  input  wire logic                                in_tlast,   // last_item
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [14:0] deviation_q4, [15] irregular, [16] too_few, [17] overflowed,
  // [24:18] used_count
  output logic [sdnn_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [sdnn_pkg::THRESH_W-1:0]       cfg_wr_data // irregular_threshold_ms
);
  import sdnn_pkg::*;

  sdnn_cmd_t    cmd;
  sdnn_status_t status;

  sdnn_ctrl #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sdnn_dp #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .interval_ms (in_tdata[INTERVAL_W-1:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
`default_nettype wire

/* rtl/core/sdnn_ctrl.sv */
`default_nettype none
module sdnn_ctrl #(
  parameter int MAX_INTERVALS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tlast,
  output logic                       in_tready,
  input  wire sdnn_pkg::sdnn_status_t status,
  output sdnn_pkg::sdnn_cmd_t        cmd
);
  import sdnn_pkg::*;

  localparam int CW    = $clog2(MAX_INTERVALS + 1);
  localparam int QW    = 16 + CW;
  localparam int CNT_W = $clog2(QW);

  sdnn_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             in_xfer;

  assign in_xfer = in_tvalid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_tlast) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = status.few ? ST_DONE : ST_SUB;
      end
      ST_SUB: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_ROOT;
        cnt_nxt   = CNT_W'(QW - 1);
      end
      ST_ROOT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DIV;
          cnt_nxt   = CNT_W'(QW - 1);
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_DONE;
        else cnt_nxt = cnt_r - 1'b1;
      end
      ST_DONE: begin
        if (!status.out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    in_tready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.acc_en = in_xfer;
      end
      ST_MUL:  cmd.mul_en   = 1'b1;
      ST_SUB:  cmd.sub_en   = 1'b1;
      ST_LOAD: cmd.load_en  = 1'b1;
      ST_ROOT: cmd.root_en  = 1'b1;
      ST_DIV:  cmd.div_en   = 1'b1;
      ST_DONE: cmd.out_load = !status.out_busy;
      default: cmd          = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/sdnn_dp.sv */
`default_nettype none
module sdnn_dp #(
  parameter int MAX_INTERVALS = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire sdnn_pkg::sdnn_cmd_t                    cmd,
  output sdnn_pkg::sdnn_status_t                      status,
  input  wire logic [sdnn_pkg::INTERVAL_W-1:0]        interval_ms,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [sdnn_pkg::THRESH_W-1:0]          cfg_wr_data,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [sdnn_pkg::OUT_TDATA_W-1:0]            out_tdata
);
  import sdnn_pkg::*;

  localparam int CW    = $clog2(MAX_INTERVALS + 1);
  localparam int SUM_W = INTERVAL_W + CW;
  localparam int SQS_W = 2 * INTERVAL_W + CW;
  localparam int SPR_W = 2 * INTERVAL_W + 2 * CW;
  localparam int LIM_W = THRESH_W + CW;
  localparam int RAD_W = SPR_W + 8;    // spread scaled by 256 for 1/16 ms
  localparam int QW    = RAD_W / 2;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

  logic [THRESH_W-1:0] thresh_r;
  logic [CW-1:0]       count_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SQS_W-1:0]    sqsum_r;
  logic                drop_r;

  logic [SPR_W-1:0]    prod_r, sq_r, spread_r, limsq_r;
  logic [LIM_W-1:0]    lim_r;
  logic                irr_r;

  logic [RAD_W-1:0]    x_r, root_r, bit_r;
  logic [CW:0]         rem_r;
  logic [QW-1:0]       quot_r;

  logic                out_valid_r;
  logic [DEV_W-1:0]    dev_r;
  logic                irr_out_r, few_out_r, ovf_out_r;
  logic [USED_W-1:0]   used_r;

  logic [RAD_W-1:0]    trial;
  logic                take;
  logic [CW:0]         rem_sh;
  logic                q_bit;
  logic                few;
  logic [DEV_W-1:0]    dev_sat;

  assign few             = count_r < CW'(2);
  assign status.few      = few;
  assign status.out_busy = out_valid_r && !out_tready;

  assign trial  = root_r + bit_r;
  assign take   = x_r >= trial;
  assign rem_sh = {rem_r[CW-1:0], root_r[QW-1]};
  assign q_bit  = rem_sh >= (CW+1)'(count_r);
  assign dev_sat = (|quot_r[QW-1:DEV_W]) ? DEV_MAX : quot_r[DEV_W-1:0];

  // config register and run accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      count_r  <= '0;
      sum_r    <= '0;
      sqsum_r  <= '0;
      drop_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) thresh_r <= cfg_wr_data;
      if (cmd.out_load) begin
        count_r <= '0;
        sum_r   <= '0;
        sqsum_r <= '0;
        drop_r  <= 1'b0;
      end else if (cmd.acc_en) begin
        if (count_r < MAX_CNT) begin
          count_r <= count_r + 1'b1;
          sum_r   <= sum_r + SUM_W'(interval_ms);
          sqsum_r <= sqsum_r + SQS_W'(interval_ms * interval_ms);
        end else begin
          drop_r <= 1'b1;
        end
      end
    end
  end

  // closing arithmetic
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= SPR_W'(count_r) * SPR_W'(sqsum_r);
      sq_r   <= SPR_W'(sum_r) * SPR_W'(sum_r);
      lim_r  <= LIM_W'(thresh_r) * LIM_W'(count_r);
    end
    if (cmd.sub_en) begin
      spread_r <= prod_r - sq_r;
      limsq_r  <= SPR_W'(lim_r) * SPR_W'(lim_r);
    end
    if (cmd.load_en) begin
      x_r    <= {spread_r, 8'd0};
      root_r <= '0;
      bit_r  <= {2'b01, {(RAD_W-2){1'b0}}};
      rem_r  <= '0;
      irr_r  <= spread_r > limsq_r;
    end
    // restoring square root, one result bit per step
    if (cmd.root_en) begin
      if (take) begin
        x_r    <= x_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    // root / n, dividend bits shifted out of root_r from the top
    if (cmd.div_en) begin
      rem_r  <= q_bit ? rem_sh - (CW+1)'(count_r) : rem_sh;
      quot_r <= {quot_r[QW-2:0], q_bit};
      root_r <= root_r << 1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dev_r     <= few ? '0 : dev_sat;
      irr_out_r <= few ? 1'b0 : irr_r;
      few_out_r <= few;
      ovf_out_r <= drop_r;
      used_r    <= USED_W'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, used_r, ovf_out_r, few_out_r, irr_out_r, dev_r};

endmodule
`default_nettype wire
